[rtl/core/stscan_pkg.sv]
// Shared types, token kind codes and character helpers for the script token scanner.
// No dependencies; used by stscan_step and script_token_scanner.
`timescale 1ns / 1ps

package stscan_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_WORD    = 2'd1,
        MODE_COMMENT = 2'd2
    } t_mode;

    localparam logic [3:0] KIND_TEXT     = 4'd0;
    localparam logic [3:0] KIND_EOL      = 4'd1;
    localparam logic [3:0] KIND_CCLOSE   = 4'd2;
    localparam logic [3:0] KIND_EQUAL    = 4'd3;
    localparam logic [3:0] KIND_KEYWORD  = 4'd4;
    localparam logic [3:0] KIND_IDENT    = 4'd5;
    localparam logic [3:0] KIND_STRING   = 4'd6;
    localparam logic [3:0] KIND_LPAREN   = 4'd7;
    localparam logic [3:0] KIND_RPAREN   = 4'd8;
    localparam logic [3:0] KIND_LBRACKET = 4'd9;
    localparam logic [3:0] KIND_RBRACKET = 4'd10;
    localparam logic [3:0] KIND_COMMA    = 4'd11;
    localparam logic [3:0] KIND_END      = 4'd12;
    localparam logic [3:0] KIND_BAD      = 4'd13;

    localparam logic [4:0] KW_LEN      = 5'd6;
    localparam logic [4:0] LEN_MAX     = 5'd31;
    localparam logic [3:0] LIMIT_RESET = 4'd10;
    localparam logic [1:0] KM_ALL      = 2'b11;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] text_byte;
        logic       last;
    } t_result;

    typedef struct packed {
        t_mode      mode;
        logic [4:0] len;
        logic [1:0] km;       // bit 0 "crypto", bit 1 "string"
        logic       started;
    } t_scan_state;

    function automatic logic is_alnum_star(input logic [7:0] c);
        is_alnum_star = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                        (c >= "0" && c <= "9") || (c == "*");
    endfunction

    function automatic logic [7:0] kw_crypto_char(input logic [2:0] pos);
        case (pos)
            3'd0:    kw_crypto_char = "c";
            3'd1:    kw_crypto_char = "r";
            3'd2:    kw_crypto_char = "y";
            3'd3:    kw_crypto_char = "p";
            3'd4:    kw_crypto_char = "t";
            3'd5:    kw_crypto_char = "o";
            default: kw_crypto_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] kw_string_char(input logic [2:0] pos);
        case (pos)
            3'd0:    kw_string_char = "s";
            3'd1:    kw_string_char = "t";
            3'd2:    kw_string_char = "r";
            3'd3:    kw_string_char = "i";
            3'd4:    kw_string_char = "n";
            3'd5:    kw_string_char = "g";
            default: kw_string_char = 8'h00;
        endcase
    endfunction

    // Keyword match bits after one more word byte at position pos.
    function automatic logic [1:0] kw_update(input logic [4:0] pos, input logic [1:0] km,
                                             input logic [7:0] c);
        logic [1:0] r;
        r = km;
        if (pos < KW_LEN) begin
            if (kw_crypto_char(pos[2:0]) != c) r[0] = 1'b0;
            if (kw_string_char(pos[2:0]) != c) r[1] = 1'b0;
        end else begin
            r = 2'b00;
        end
        kw_update = r;
    endfunction

endpackage

[rtl/core/stscan_step.sv]
// Per-byte scan decision: next scanner state and up to two token results.
// Depends on stscan_pkg.
`timescale 1ns / 1ps

module stscan_step (
    input  logic [7:0]            i_ch,
    input  logic [3:0]            i_limit,
    input  stscan_pkg::t_scan_state i_state,
    output stscan_pkg::t_scan_state o_state,
    output logic [1:0]            o_count,
    output stscan_pkg::t_result   o_res0,
    output stscan_pkg::t_result   o_res1
);

    logic                    is_an;
    // idle-path result and state
    logic                    idl_has;
    logic [3:0]              idl_kind;
    logic [7:0]              idl_txt;
    stscan_pkg::t_scan_state idl_state;
    // result emitted before the idle path (word close or comment close)
    logic                    pre_has;
    logic [3:0]              pre_kind;
    logic                    use_idle;
    logic                    direct_has;
    stscan_pkg::t_result     direct_res;

    always_comb begin
        is_an = stscan_pkg::is_alnum_star(i_ch);

        // byte handled with no token open
        idl_has           = 1'b1;
        idl_kind          = stscan_pkg::KIND_BAD;
        idl_txt           = 8'h00;
        idl_state         = i_state;
        idl_state.mode    = stscan_pkg::MODE_IDLE;
        idl_state.started = 1'b1;
        if (i_ch == 8'h00) begin
            idl_has       = i_state.started;
            idl_kind      = stscan_pkg::KIND_END;
            idl_state.len = 5'd0;
            idl_state.km  = stscan_pkg::KM_ALL;
            idl_state.started = 1'b0;
        end else if (is_an) begin
            idl_kind       = stscan_pkg::KIND_TEXT;
            idl_txt        = i_ch;
            idl_state.mode = stscan_pkg::MODE_WORD;
            idl_state.len  = 5'd1;
            idl_state.km   = stscan_pkg::kw_update(5'd0, stscan_pkg::KM_ALL, i_ch);
        end else begin
            case (i_ch)
                8'h0A: idl_kind = stscan_pkg::KIND_EOL;
                ";", "/": begin
                    idl_kind       = stscan_pkg::KIND_TEXT;
                    idl_txt        = i_ch;
                    idl_state.mode = stscan_pkg::MODE_COMMENT;
                end
                " ", ".", 8'h09, 8'h0D: idl_has = 1'b0;
                "=": idl_kind = stscan_pkg::KIND_EQUAL;
                "(": idl_kind = stscan_pkg::KIND_LPAREN;
                ")": idl_kind = stscan_pkg::KIND_RPAREN;
                "[": idl_kind = stscan_pkg::KIND_LBRACKET;
                "]": idl_kind = stscan_pkg::KIND_RBRACKET;
                ",": idl_kind = stscan_pkg::KIND_COMMA;
                default: idl_txt = i_ch;
            endcase
        end

        pre_has    = 1'b0;
        pre_kind   = stscan_pkg::KIND_STRING;
        use_idle   = 1'b0;
        direct_has = 1'b0;
        direct_res = '{kind: stscan_pkg::KIND_TEXT, text_byte: i_ch, last: 1'b1};
        o_state    = i_state;

        case (i_state.mode)
            stscan_pkg::MODE_WORD: begin
                if (is_an || i_ch == "_" || i_ch == "-") begin
                    direct_has = 1'b1;
                    o_state.km = stscan_pkg::kw_update(i_state.len, i_state.km, i_ch);
                    if (i_state.len < stscan_pkg::LEN_MAX) o_state.len = i_state.len + 5'd1;
                end else if (i_ch != " ") begin
                    pre_has  = 1'b1;
                    use_idle = 1'b1;
                    if (i_state.len == stscan_pkg::KW_LEN && i_state.km != 2'b00)
                        pre_kind = stscan_pkg::KIND_KEYWORD;
                    else if (i_ch == "(" || (i_ch == "=" && i_state.len <= {1'b0, i_limit}))
                        pre_kind = stscan_pkg::KIND_IDENT;
                    else
                        pre_kind = stscan_pkg::KIND_STRING;
                end
            end
            stscan_pkg::MODE_COMMENT: begin
                if (i_ch != 8'h0A && i_ch != 8'h00) begin
                    direct_has = 1'b1;
                end else begin
                    pre_has  = 1'b1;
                    pre_kind = stscan_pkg::KIND_CCLOSE;
                    use_idle = 1'b1;
                end
            end
            default: use_idle = 1'b1;
        endcase

        if (use_idle) o_state = idl_state;

        o_count = 2'd0;
        o_res0  = direct_res;
        o_res1  = '{kind: idl_kind, text_byte: idl_txt, last: 1'b1};
        if (direct_has) begin
            o_count = 2'd1;
        end else if (pre_has) begin
            o_res0 = '{kind: pre_kind, text_byte: 8'h00, last: !(use_idle && idl_has)};
            o_count = (use_idle && idl_has) ? 2'd2 : 2'd1;
        end else if (use_idle && idl_has) begin
            o_res0  = '{kind: idl_kind, text_byte: idl_txt, last: 1'b1};
            o_count = 2'd1;
        end
    end

endmodule

[rtl/core/script_token_scanner.sv]
// Top level of the script token scanner: state registers, config register, result queue.
// Depends on stscan_pkg and stscan_step.
`timescale 1ns / 1ps
//
//  channel   direction  signals                              beat
//  --------  ---------  -----------------------------------  ---------------------------
//  source    in         i_valid / o_ready, i_ch              one source byte
//  token     out        o_valid / i_ready, o_kind,           one token result
//                       o_text_byte, o_last
//  config    in         i_cfg_we, i_cfg_data                 ident_len_limit write
//
//  A source beat is decided in the cycle it is accepted: the scanner state updates at
//  that edge and its 0..2 results enter a 4-entry result queue, whose head drives the
//  token channel. One byte per cycle is taken while o_ready is high; o_ready drops when
//  the queue holds three or more results, so a byte that makes two results, or a stalled
//  token side, slows intake to the rate results leave.
//  Reset (synchronous, active low) empties the queue, returns the scanner to idle with
//  no source started and sets ident_len_limit to 10.
//
module script_token_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // source bytes
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_ch,
    // configuration
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    // token results
    output logic       o_valid,
    input  logic       i_ready,
    output logic [3:0] o_kind,
    output logic [7:0] o_text_byte,
    output logic       o_last
);

    localparam int QDEPTH = 4;

    stscan_pkg::t_scan_state r_state, n_state;
    logic [3:0]              r_limit;
    stscan_pkg::t_result     r_q [QDEPTH];
    stscan_pkg::t_result     n_q [QDEPTH];
    logic [2:0]              r_cnt, n_cnt;

    stscan_pkg::t_scan_state step_state;
    logic [1:0]              step_count;
    stscan_pkg::t_result     step_res0, step_res1;

    logic                    in_acc;
    logic                    pop;
    logic [2:0]              base;

    stscan_step u_step (
        .i_ch    (i_ch),
        .i_limit (r_limit),
        .i_state (r_state),
        .o_state (step_state),
        .o_count (step_count),
        .o_res0  (step_res0),
        .o_res1  (step_res1)
    );

    // room for two more results regardless of the token side
    assign o_ready = (r_cnt <= 3'd2);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = (r_cnt != 3'd0);
    assign pop     = o_valid && i_ready;

    assign o_kind      = r_q[0].kind;
    assign o_text_byte = r_q[0].text_byte;
    assign o_last      = r_q[0].last;

    always_comb begin
        n_state = in_acc ? step_state : r_state;
        base    = r_cnt - {2'b00, pop};
        // shift queue: head leaves at index 0, new results land behind the survivors
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && i < QDEPTH - 1) n_q[i] = r_q[i + 1];
            else                       n_q[i] = r_q[i];
            if (in_acc && step_count != 2'd0 && base == 3'(i)) n_q[i] = step_res0;
            if (in_acc && step_count == 2'd2 && base + 3'd1 == 3'(i)) n_q[i] = step_res1;
        end
        n_cnt = base + (in_acc ? {1'b0, step_count} : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: stscan_pkg::MODE_IDLE, len: 5'd0,
                         km: stscan_pkg::KM_ALL, started: 1'b0};
            r_limit <= stscan_pkg::LIMIT_RESET;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) r_limit <= i_cfg_data;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDEPTH; i++) r_q[i] <= n_q[i];
    end

endmodule
